// ===== sv/scli_pkg.sv =====
// Shared types, request codes and quarter-wave tables for the sine/cosine block.
// No dependencies; imported by scli_rom and sine_cosine_lut_interp.
package scli_pkg;

  typedef enum logic [1:0] {
    REQ_SIN8  = 2'd0,
    REQ_COS8  = 2'd1,
    REQ_SIN16 = 2'd2,
    REQ_COS16 = 2'd3
  } req_t;

  localparam int QIDX_W = 7;   // folded index 0..64
  localparam int MAG_W  = 15;  // table magnitude 0..32767
  localparam int QLEN   = 65;

  localparam logic [7:0]  QUARTER8  = 8'h40;
  localparam logic [15:0] QUARTER16 = 16'h4000;
  localparam logic [QIDX_W-1:0] FOLD_TOP = 7'd64;

  // Table read request for both samples of one transaction
  typedef struct packed {
    logic              short_form;
    logic [QIDX_W-1:0] k0;
    logic [QIDX_W-1:0] k1;
  } scli_rd_t;

  localparam logic [MAG_W-1:0] Q8 [QLEN] = '{
      15'd0,   15'd3,   15'd6,   15'd9,   15'd12,  15'd15,  15'd18,  15'd21,
      15'd24,  15'd27,  15'd30,  15'd34,  15'd37,  15'd39,  15'd42,  15'd45,
      15'd48,  15'd51,  15'd54,  15'd57,  15'd60,  15'd62,  15'd65,  15'd68,
      15'd70,  15'd73,  15'd75,  15'd78,  15'd80,  15'd83,  15'd85,  15'd87,
      15'd90,  15'd92,  15'd94,  15'd96,  15'd98,  15'd100, 15'd102, 15'd104,
      15'd106, 15'd107, 15'd109, 15'd110, 15'd112, 15'd113, 15'd115, 15'd116,
      15'd117, 15'd118, 15'd120, 15'd121, 15'd122, 15'd122, 15'd123, 15'd124,
      15'd125, 15'd125, 15'd126, 15'd126, 15'd126, 15'd127, 15'd127, 15'd127,
      15'd127
  };

  localparam logic [MAG_W-1:0] Q16 [QLEN] = '{
      15'd0,     15'd804,   15'd1608,  15'd2410,  15'd3212,  15'd4011,  15'd4808,
      15'd5602,  15'd6393,  15'd7179,  15'd7962,  15'd8739,  15'd9512,  15'd10278,
      15'd11039, 15'd11793, 15'd12539, 15'd13279, 15'd14010, 15'd14732, 15'd15446,
      15'd16151, 15'd16846, 15'd17530, 15'd18204, 15'd18868, 15'd19519, 15'd20159,
      15'd20787, 15'd21403, 15'd22005, 15'd22594, 15'd23170, 15'd23731, 15'd24279,
      15'd24811, 15'd25329, 15'd25832, 15'd26319, 15'd26790, 15'd27245, 15'd27683,
      15'd28105, 15'd28510, 15'd28898, 15'd29268, 15'd29621, 15'd29956, 15'd30273,
      15'd30571, 15'd30852, 15'd31113, 15'd31356, 15'd31580, 15'd31785, 15'd31971,
      15'd32137, 15'd32285, 15'd32412, 15'd32521, 15'd32609, 15'd32678, 15'd32728,
      15'd32757, 15'd32767
  };

  // Fold an 8-bit phase into the quarter-wave index (mirror on bit 6)
  function automatic logic [QIDX_W-1:0] fold_index(input logic [7:0] ph);
    logic [QIDX_W-1:0] k;
    k = {1'b0, ph[5:0]};
    if (ph[6]) begin
      k = FOLD_TOP - k;
    end
    return k;
  endfunction

endpackage

// ===== sv/scli_rom.sv =====
// Dual-read quarter-wave ROM with registered outputs.
// Depends on scli_pkg for the tables and the read request struct.
module scli_rom (
  input  logic                             clk,
  input  scli_pkg::scli_rd_t               rd,
  output logic [scli_pkg::MAG_W-1:0]       mag0,
  output logic [scli_pkg::MAG_W-1:0]       mag1
);
  import scli_pkg::*;

  logic [MAG_W-1:0] mag0_r, mag1_r;
  logic [MAG_W-1:0] mag0_nxt, mag1_nxt;

  always_comb begin
    if (rd.short_form) begin
      mag0_nxt = Q8[rd.k0];
      mag1_nxt = Q8[rd.k1];
    end else begin
      mag0_nxt = Q16[rd.k0];
      mag1_nxt = Q16[rd.k1];
    end
  end

  always_ff @(posedge clk) begin
    mag0_r <= mag0_nxt;
    mag1_r <= mag1_nxt;
  end

  assign mag0 = mag0_r;
  assign mag1 = mag1_r;

endmodule

// ===== sv/sine_cosine_lut_interp.sv =====
// Sine/cosine by quarter-wave table lookup with linear interpolation.
// Depends on scli_pkg and scli_rom.
//
// Usage:
//   Input: a transaction is taken at each rising edge with start high and
//   busy low. busy is always low, so one transaction per cycle is sustained.
//   in_req_type selects 8-bit sine/cosine (angle bits 7..0, full turn 256)
//   or 16-bit sine/cosine (full turn 65536). Cosine adds a quarter turn.
//   Output: out_valid strobes for one cycle with out_value, in input order.
//   The receiver cannot stall; results must be taken when strobed.
//   Pipeline:
//     stage 1 - phase offset, fold, ROM read of both samples (registered)
//     stage 2 - sign the samples, difference times fraction (one 18x9 mult)
//     stage 3 - blend add, floor by 256, output register
//   The short forms run the same path with fraction zero, so the blend
//   returns the first sample unchanged.
//   Each result passes the ROM read register, the multiplier register and
//   the output register in turn.
//   Reset (rst_n low, synchronous) clears the valid pipeline only; no
//   results are produced for transactions in flight during reset.
module sine_cosine_lut_interp (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_angle,
  output logic        out_valid,
  output logic signed [15:0] out_value
);
  import scli_pkg::*;

  // ---------------- stage 0: phase and fold ----------------
  req_t       req;
  logic       is_cos, is_long;
  logic [7:0] ph8, hi, hi1, frac;
  logic [15:0] ph16;
  scli_rd_t   rd;

  assign req     = req_t'(in_req_type);
  assign is_cos  = (req == REQ_COS8) || (req == REQ_COS16);
  assign is_long = (req == REQ_SIN16) || (req == REQ_COS16);

  always_comb begin
    ph8  = in_angle[7:0] + (is_cos ? QUARTER8 : 8'd0);
    ph16 = in_angle + (is_cos ? QUARTER16 : 16'd0);
    hi   = is_long ? ph16[15:8] : ph8;
    hi1  = hi + 8'd1;         // wraps from 255 to 0
    frac = is_long ? ph16[7:0] : 8'd0;
    rd.short_form = !is_long;
    rd.k0 = fold_index(hi);
    rd.k1 = fold_index(hi1);
  end

  // ---------------- stage 1: table read ----------------
  logic [MAG_W-1:0] mag0, mag1;

  scli_rom u_rom (
    .clk  (clk),
    .rd   (rd),
    .mag0 (mag0),
    .mag1 (mag1)
  );

  logic       v1_r, neg0_r, neg1_r;
  logic [7:0] frac1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
    neg0_r  <= hi[7];
    neg1_r  <= hi1[7];
    frac1_r <= frac;
  end

  // ---------------- stage 2: sign and multiply ----------------
  logic signed [16:0] s0, s1;
  logic signed [17:0] diff;
  logic signed [26:0] prod_nxt;

  always_comb begin
    s0 = neg0_r ? -$signed({2'b00, mag0}) : $signed({2'b00, mag0});
    s1 = neg1_r ? -$signed({2'b00, mag1}) : $signed({2'b00, mag1});
    diff = 18'(s1) - 18'(s0);
    prod_nxt = 27'(diff) * 27'($signed({1'b0, frac1_r}));
  end

  logic               v2_r;
  logic signed [16:0] s0_r;
  logic signed [26:0] prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    s0_r   <= s0;
    prod_r <= prod_nxt;
  end

  // ---------------- stage 3: blend and floor ----------------
  logic signed [27:0] blend;
  logic signed [15:0] out_value_nxt;
  logic               out_valid_r;
  logic signed [15:0] out_value_r;

  always_comb begin
    blend = 28'({s0_r, 8'd0}) + 28'(prod_r);
    out_value_nxt = blend[23:8];  // floor of blend / 256
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v2_r;
    end
    out_value_r <= out_value_nxt;
  end

  assign busy      = 1'b0;
  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

endmodule

// ===== sv/scli_chk.sv =====
// Port-level checker for sine_cosine_lut_interp, attached by bind.
// Depends only on the top level's ports.
module scli_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_req_type,
  input logic        out_valid,
  input logic signed [15:0] out_value
);

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("accepted transaction produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##3 !out_valid)
    else $error("result without a transaction");

  a_short_range: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_req_type[1]) |->
      ##3 (out_value <= 16'sd127 && out_value >= -16'sd127))
    else $error("short form result out of range");

  a_no_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_value != -16'sd32768))
    else $error("result hit the negative limit");

endmodule

bind sine_cosine_lut_interp scli_chk u_scli_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .in_req_type (in_req_type),
  .out_valid   (out_valid),
  .out_value   (out_value)
);
